>>> rtl/yuv2argb_pkg.sv
// ----------------------------------------------------------------------------
// yuv2argb_pkg
// Shared widths, register indexes and reset values of the YUV to ARGB
// pixel converter.
// ----------------------------------------------------------------------------
package yuv2argb_pkg;

  // Field widths
  localparam int SAMPLE_W   = 8;
  localparam int IN_DATA_W  = 3 * SAMPLE_W;
  localparam int OUT_DATA_W = 32;
  localparam int GAIN_W     = 18;
  localparam int OFFSET_W   = 25;
  localparam int COEF_W     = 19;
  localparam int RANGE_W    = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = OFFSET_W;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_Y_GAIN      = 3'd0,
    REG_Y_OFFSET    = 3'd1,
    REG_CR_TO_RED   = 3'd2,
    REG_CB_TO_BLUE  = 3'd3,
    REG_CB_TO_GREEN = 3'd4,
    REG_CR_TO_GREEN = 3'd5,
    REG_RANGE_OFS   = 3'd6
  } cfg_reg_t;

  // Reset values
  localparam logic [GAIN_W-1:0]          RST_Y_GAIN      = 18'd65536;
  localparam logic signed [OFFSET_W-1:0] RST_Y_OFFSET    = 25'sd0;
  localparam logic signed [COEF_W-1:0]   RST_CR_TO_RED   = 19'sd91881;
  localparam logic signed [COEF_W-1:0]   RST_CB_TO_BLUE  = 19'sd116129;
  localparam logic signed [COEF_W-1:0]   RST_CB_TO_GREEN = -19'sd22552;
  localparam logic signed [COEF_W-1:0]   RST_CR_TO_GREEN = -19'sd46800;
  localparam logic [RANGE_W-1:0]         RST_RANGE_OFS   = 10'd384;

  // Fixed constant of the alpha channel
  localparam logic [7:0] ALPHA_BYTE = 8'hFF;

endpackage

>>> rtl/yuv_to_argb_pixel_converter.sv
// ----------------------------------------------------------------------------
// yuv_to_argb_pixel_converter
// Converts one pixel (luma plus its shared chroma) to a 32-bit ARGB word.
// ----------------------------------------------------------------------------
// The converter takes one pixel per clock unless the output stalls. It is a
// four-stage pipeline: chroma products, index sum and clamp, luma gain
// product, offset/round/clip into the output register. All stages move
// together on one enable, so a stall on the output holds every stage in
// place and in_tready drops only while the output register is full and not
// taken. The user must write coefficients through the cfg port only while
// the stream is idle; the block itself does not enforce this.
// Unknown indexes are ignored. Alpha is always 255.
// ----------------------------------------------------------------------------
module yuv_to_argb_pixel_converter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [yuv2argb_pkg::IN_DATA_W-1:0]   in_tdata,   // luma, chroma_blue, chroma_red
  // output stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [yuv2argb_pkg::OUT_DATA_W-1:0]  out_tdata,  // argb_word
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [yuv2argb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [yuv2argb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import yuv2argb_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0]          y_gain_r;
  logic signed [OFFSET_W-1:0] y_offset_r;
  logic signed [COEF_W-1:0]   cr_to_red_r;
  logic signed [COEF_W-1:0]   cb_to_blue_r;
  logic signed [COEF_W-1:0]   cb_to_green_r;
  logic signed [COEF_W-1:0]   cr_to_green_r;
  logic [RANGE_W-1:0]         range_ofs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_gain_r      <= RST_Y_GAIN;
      y_offset_r    <= RST_Y_OFFSET;
      cr_to_red_r   <= RST_CR_TO_RED;
      cb_to_blue_r  <= RST_CB_TO_BLUE;
      cb_to_green_r <= RST_CB_TO_GREEN;
      cr_to_green_r <= RST_CR_TO_GREEN;
      range_ofs_r   <= RST_RANGE_OFS;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_Y_GAIN:      y_gain_r      <= cfg_wdata[GAIN_W-1:0];
        REG_Y_OFFSET:    y_offset_r    <= $signed(cfg_wdata[OFFSET_W-1:0]);
        REG_CR_TO_RED:   cr_to_red_r   <= $signed(cfg_wdata[COEF_W-1:0]);
        REG_CB_TO_BLUE:  cb_to_blue_r  <= $signed(cfg_wdata[COEF_W-1:0]);
        REG_CB_TO_GREEN: cb_to_green_r <= $signed(cfg_wdata[COEF_W-1:0]);
        REG_CR_TO_GREEN: cr_to_green_r <= $signed(cfg_wdata[COEF_W-1:0]);
        REG_RANGE_OFS:   range_ofs_r   <= cfg_wdata[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Local widths
  // --------------------------------------------------------------------------
  localparam int PROD_W  = COEF_W + SAMPLE_W + 1;    // k * C, signed
  localparam int TERM_W  = PROD_W - 16 + 1;          // floor(kC/2^16) - floor(k/2^9)
  localparam int BASE_W  = RANGE_W + 1;              // luma + range offset
  localparam int IDX_W   = TERM_W + 2;               // base plus two terms
  localparam int TIDX_W  = 10;                       // clamped index 0..1023
  localparam int DIFF_W  = TIDX_W + 1;               // index - 384, signed
  localparam int GPROD_W = DIFF_W + GAIN_W + 1;      // diff * y_gain, signed
  localparam int SUM_W   = 32;
  localparam int Q_W     = SUM_W - 16;

  localparam logic signed [DIFF_W-1:0] IDX_CENTER = 11'sd384;
  localparam logic signed [SUM_W-1:0]  ROUND_HALF = 32'sh0000_8000;

  // Clamp a signed index into 0..1023
  function automatic logic [TIDX_W-1:0] clamp_idx(input logic signed [IDX_W-1:0] v);
    logic [TIDX_W-1:0] res;
    if (v < 0)
      res = '0;
    else if (v > $signed(IDX_W'(1023)))
      res = '1;
    else
      res = v[TIDX_W-1:0];
    return res;
  endfunction

  // Offset, round, floor-shift and clip one channel product to 8 bits
  function automatic logic [7:0] finish_chan(input logic signed [GPROD_W-1:0] p,
                                             input logic signed [OFFSET_W-1:0] ofs);
    logic signed [SUM_W-1:0] s;
    logic signed [Q_W-1:0]   q;
    logic [7:0]              res;
    s = SUM_W'(p) - SUM_W'(ofs) + ROUND_HALF;
    q = s[SUM_W-1:16];
    if (q < 0)
      res = 8'd0;
    else if (q > $signed(Q_W'(255)))
      res = 8'hFF;
    else
      res = q[7:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Pipeline enable: every stage advances unless the output is stalled
  // --------------------------------------------------------------------------
  logic adv;
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;

  assign adv       = !s4_vld_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_tvalid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: chroma products and index base
  // --------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] luma, chroma_blue, chroma_red;
  assign luma        = in_tdata[SAMPLE_W-1:0];
  assign chroma_blue = in_tdata[2*SAMPLE_W-1:SAMPLE_W];
  assign chroma_red  = in_tdata[3*SAMPLE_W-1:2*SAMPLE_W];

  logic signed [PROD_W-1:0] p_red_r, p_blue_r, p_gcb_r, p_gcr_r;
  logic [BASE_W-1:0]        base_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_red_r  <= PROD_W'(cr_to_red_r   * $signed({1'b0, chroma_red}));
      p_blue_r <= PROD_W'(cb_to_blue_r  * $signed({1'b0, chroma_blue}));
      p_gcb_r  <= PROD_W'(cb_to_green_r * $signed({1'b0, chroma_blue}));
      p_gcr_r  <= PROD_W'(cr_to_green_r * $signed({1'b0, chroma_red}));
      base_r   <= BASE_W'(luma) + BASE_W'(range_ofs_r);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: chroma terms, channel indexes, clamp
  // --------------------------------------------------------------------------
  logic signed [TERM_W-1:0] t_red, t_blue, t_gcb, t_gcr;
  logic signed [IDX_W-1:0]  i_red, i_green, i_blue, base_s;

  assign t_red  = TERM_W'($signed(p_red_r[PROD_W-1:16]))
                - TERM_W'($signed(cr_to_red_r[COEF_W-1:9]));
  assign t_blue = TERM_W'($signed(p_blue_r[PROD_W-1:16]))
                - TERM_W'($signed(cb_to_blue_r[COEF_W-1:9]));
  assign t_gcb  = TERM_W'($signed(p_gcb_r[PROD_W-1:16]))
                - TERM_W'($signed(cb_to_green_r[COEF_W-1:9]));
  assign t_gcr  = TERM_W'($signed(p_gcr_r[PROD_W-1:16]))
                - TERM_W'($signed(cr_to_green_r[COEF_W-1:9]));

  assign base_s  = $signed(IDX_W'(base_r));
  assign i_red   = base_s + IDX_W'(t_red);
  assign i_blue  = base_s + IDX_W'(t_blue);
  assign i_green = base_s + IDX_W'(t_gcb) + IDX_W'(t_gcr);

  logic [TIDX_W-1:0] ix_red_r, ix_green_r, ix_blue_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ix_red_r   <= clamp_idx(i_red);
      ix_green_r <= clamp_idx(i_green);
      ix_blue_r  <= clamp_idx(i_blue);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: luma gain products
  // --------------------------------------------------------------------------
  logic signed [DIFF_W-1:0]  d_red, d_green, d_blue;
  logic signed [GAIN_W:0]    gain_s;
  logic signed [GPROD_W-1:0] g_red_r, g_green_r, g_blue_r;

  assign d_red   = $signed({1'b0, ix_red_r})   - IDX_CENTER;
  assign d_green = $signed({1'b0, ix_green_r}) - IDX_CENTER;
  assign d_blue  = $signed({1'b0, ix_blue_r})  - IDX_CENTER;
  assign gain_s  = $signed({1'b0, y_gain_r});

  always_ff @(posedge clk) begin
    if (adv) begin
      g_red_r   <= GPROD_W'(d_red   * gain_s);
      g_green_r <= GPROD_W'(d_green * gain_s);
      g_blue_r  <= GPROD_W'(d_blue  * gain_s);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: offset, round, clip and pack into the output register
  // --------------------------------------------------------------------------
  logic [OUT_DATA_W-1:0] argb_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      argb_r <= {ALPHA_BYTE,
                 finish_chan(g_red_r,   y_offset_r),
                 finish_chan(g_green_r, y_offset_r),
                 finish_chan(g_blue_r,  y_offset_r)};
    end
  end

  assign out_tvalid = s4_vld_r;
  assign out_tdata  = argb_r;

endmodule
